[src/tftt_pkg.sv]
`default_nettype none

package tftt_pkg;

    // Command codes carried by a request.
    typedef enum logic [1:0] {
        CMD_PUSH = 2'd0,
        CMD_POP  = 2'd1,
        CMD_SET  = 2'd2,
        CMD_TICK = 2'd3
    } cmd_t;

    // Task id that marks the idle task and free places.
    localparam logic [7:0] NO_TASK = 8'd0;

    // Count value at which a timed task is released on a tick.
    localparam logic [15:0] EXPIRE_COUNT = 16'd1;

    // One word of the timer table memory.
    typedef struct packed {
        logic [7:0]  task_id;
        logic [15:0] count;
    } timer_entry_t;

endpackage

`default_nettype wire

[src/task_fifo_with_timer_table_top.sv]
`default_nettype none

// Channel  | Handshake              | Payload
// ---------+------------------------+----------------------------------------------
// request  | in_valid / in_ready    | command, task_id, delay
// result   | out_valid / out_ready  | next_task, task_valid, push_dropped, timer_full
//
// One request is worked on at a time; each request gives exactly one result.
// Push, pop of an empty queue and set timer of the idle task go straight to
// the finish state; a pop first reads the ready queue memory.
// Tick and set timer walk the timer table memory one slot per cycle through
// its single read port; set timer then has a further state to claim a free slot.
// Reset clears the queue pointers and the per-slot valid bits; no memory sweep.
// A new request is taken while an earlier result still waits in the output
// register; the block stalls only when a finished result finds it still full.
module task_fifo_with_timer_table_top #(
    parameter int QUEUE_SLOTS = 8,
    parameter int TIMER_SLOTS = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  command,
    input  wire logic [7:0]  task_id,
    input  wire logic [15:0] delay,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       next_task,
    output logic             task_valid,
    output logic             push_dropped,
    output logic             timer_full
);

    localparam int QW = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
    localparam int CW = $clog2(QUEUE_SLOTS + 1);
    localparam int TW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam logic [QW-1:0] PTR_LAST  = QW'(QUEUE_SLOTS - 1);
    localparam logic [CW-1:0] QUEUE_CAP = CW'(QUEUE_SLOTS);
    localparam logic [TW-1:0] SLOT_LAST = TW'(TIMER_SLOTS - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POP,
        ST_WALK,
        ST_SETW,
        ST_FINISH
    } state_t;

    // Control and result registers.
    state_t             state_reg, state_next;
    tftt_pkg::cmd_t     cmd_reg, cmd_next;
    logic [7:0]         id_reg, id_next;
    logic [15:0]        delay_reg, delay_next;
    logic [QW-1:0]      head_reg, head_next;
    logic [QW-1:0]      tail_reg, tail_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [TIMER_SLOTS-1:0] tvalid_reg, tvalid_next;
    logic               issue_on_reg, issue_on_next;
    logic [TW-1:0]      issue_idx_reg, issue_idx_next;
    logic               rd_vld_reg, rd_vld_next;
    logic [TW-1:0]      rd_idx_reg, rd_idx_next;
    logic               match_reg, match_next;
    logic               free_reg, free_next;
    logic [TW-1:0]      free_idx_reg, free_idx_next;
    logic [7:0]         res_task_reg, res_task_next;
    logic               res_drop_reg, res_drop_next;
    logic               res_full_reg, res_full_next;
    logic               out_valid_reg, out_valid_next;
    logic [7:0]         next_task_reg, next_task_next;
    logic               task_valid_reg, task_valid_next;
    logic               push_dropped_reg, push_dropped_next;
    logic               timer_full_reg, timer_full_next;

    // Memory ports.
    logic [7:0]             fifo_mem [QUEUE_SLOTS];
    logic [7:0]             fifo_q;
    logic                   fifo_we;
    logic [QW-1:0]          fifo_waddr;
    logic [7:0]             fifo_wdata;
    logic                   fifo_re;
    tftt_pkg::timer_entry_t timer_mem [TIMER_SLOTS];
    tftt_pkg::timer_entry_t timer_q;
    logic                   tm_we;
    logic [TW-1:0]          tm_waddr;
    tftt_pkg::timer_entry_t tm_wdata;
    logic                   tm_re;

    logic                   in_fire;
    tftt_pkg::cmd_t         in_cmd;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign in_cmd   = tftt_pkg::cmd_t'(command);

    // Next-state logic: queue bookkeeping, timer walk and result assembly.
    always_comb
    begin
        state_next        = state_reg;
        cmd_next          = cmd_reg;
        id_next           = id_reg;
        delay_next        = delay_reg;
        head_next         = head_reg;
        tail_next         = tail_reg;
        count_next        = count_reg;
        tvalid_next       = tvalid_reg;
        issue_on_next     = issue_on_reg;
        issue_idx_next    = issue_idx_reg;
        rd_vld_next       = 1'b0;
        rd_idx_next       = rd_idx_reg;
        match_next        = match_reg;
        free_next         = free_reg;
        free_idx_next     = free_idx_reg;
        res_task_next     = res_task_reg;
        res_drop_next     = res_drop_reg;
        res_full_next     = res_full_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        next_task_next    = next_task_reg;
        task_valid_next   = task_valid_reg;
        push_dropped_next = push_dropped_reg;
        timer_full_next   = timer_full_reg;
        fifo_we           = 1'b0;
        fifo_waddr        = tail_reg;
        fifo_wdata        = task_id;
        fifo_re           = 1'b0;
        tm_we             = 1'b0;
        tm_waddr          = rd_idx_reg;
        tm_wdata          = timer_q;
        tm_re             = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    cmd_next       = in_cmd;
                    id_next        = task_id;
                    delay_next     = delay;
                    res_task_next  = tftt_pkg::NO_TASK;
                    res_drop_next  = 1'b0;
                    res_full_next  = 1'b0;
                    match_next     = 1'b0;
                    free_next      = 1'b0;
                    free_idx_next  = '0;
                    issue_on_next  = 1'b1;
                    issue_idx_next = '0;
                    state_next     = ST_FINISH;
                    case (in_cmd)
                        tftt_pkg::CMD_PUSH:
                        begin
                            // Append unless idle; drop when the queue is full.
                            if (task_id != tftt_pkg::NO_TASK)
                            begin
                                if (count_reg < QUEUE_CAP)
                                begin
                                    fifo_we    = 1'b1;
                                    tail_next  = (tail_reg == PTR_LAST) ? '0 : tail_reg + 1'b1;
                                    count_next = count_reg + 1'b1;
                                end
                                else
                                begin
                                    res_drop_next = 1'b1;
                                end
                            end
                        end
                        tftt_pkg::CMD_POP:
                        begin
                            // Read the head; an empty queue answers idle at once.
                            if (count_reg != '0)
                            begin
                                fifo_re    = 1'b1;
                                head_next  = (head_reg == PTR_LAST) ? '0 : head_reg + 1'b1;
                                count_next = count_reg - 1'b1;
                                state_next = ST_POP;
                            end
                        end
                        tftt_pkg::CMD_SET:
                        begin
                            if (task_id != tftt_pkg::NO_TASK)
                            begin
                                state_next = ST_WALK;
                            end
                        end
                        tftt_pkg::CMD_TICK:
                        begin
                            state_next = ST_WALK;
                        end
                        default:
                        begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end

            ST_POP:
            begin
                res_task_next = fifo_q;
                state_next    = ST_FINISH;
            end

            ST_WALK:
            begin
                // Issue stage: read one timer slot per cycle.
                if (issue_on_reg)
                begin
                    tm_re       = 1'b1;
                    rd_vld_next = 1'b1;
                    rd_idx_next = issue_idx_reg;
                    if (issue_idx_reg == SLOT_LAST)
                    begin
                        issue_on_next = 1'b0;
                    end
                    else
                    begin
                        issue_idx_next = issue_idx_reg + 1'b1;
                    end
                end

                // Process stage: act on the slot read in the previous cycle.
                if (rd_vld_reg)
                begin
                    if (cmd_reg == tftt_pkg::CMD_TICK)
                    begin
                        if (tvalid_reg[rd_idx_reg])
                        begin
                            if (timer_q.count == tftt_pkg::EXPIRE_COUNT)
                            begin
                                tvalid_next[rd_idx_reg] = 1'b0;
                                fifo_wdata = timer_q.task_id;
                                if (count_reg < QUEUE_CAP)
                                begin
                                    fifo_we    = 1'b1;
                                    tail_next  = (tail_reg == PTR_LAST) ? '0 : tail_reg + 1'b1;
                                    count_next = count_reg + 1'b1;
                                end
                                else
                                begin
                                    res_drop_next = 1'b1;
                                end
                            end
                            else
                            begin
                                tm_we          = 1'b1;
                                tm_wdata.count = timer_q.count - 16'd1;
                            end
                        end
                    end
                    else
                    begin
                        // Set timer: re-time the first match, note the first free slot.
                        if (!match_reg && tvalid_reg[rd_idx_reg] && timer_q.task_id == id_reg)
                        begin
                            tm_we      = 1'b1;
                            tm_wdata   = '{task_id: id_reg, count: delay_reg};
                            match_next = 1'b1;
                        end
                        if (!tvalid_reg[rd_idx_reg] && !free_reg)
                        begin
                            free_next     = 1'b1;
                            free_idx_next = rd_idx_reg;
                        end
                    end

                    if (rd_idx_reg == SLOT_LAST)
                    begin
                        state_next = (cmd_reg == tftt_pkg::CMD_SET) ? ST_SETW : ST_FINISH;
                    end
                end
            end

            ST_SETW:
            begin
                // No match: take the first free slot, or flag a full table.
                if (!match_reg)
                begin
                    if (free_reg)
                    begin
                        tm_we                     = 1'b1;
                        tm_waddr                  = free_idx_reg;
                        tm_wdata                  = '{task_id: id_reg, count: delay_reg};
                        tvalid_next[free_idx_reg] = 1'b1;
                    end
                    else
                    begin
                        res_full_next = 1'b1;
                    end
                end
                state_next = ST_FINISH;
            end

            ST_FINISH:
            begin
                // Hand the result over once the output register is free.
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next    = 1'b1;
                    next_task_next    = res_task_reg;
                    task_valid_next   = (res_task_reg != tftt_pkg::NO_TASK);
                    push_dropped_next = res_drop_reg;
                    timer_full_next   = res_full_reg;
                    state_next        = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            tvalid_reg    <= '0;
            issue_on_reg  <= 1'b0;
            issue_idx_reg <= '0;
            rd_vld_reg    <= 1'b0;
            match_reg     <= 1'b0;
            free_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            tvalid_reg    <= tvalid_next;
            issue_on_reg  <= issue_on_next;
            issue_idx_reg <= issue_idx_next;
            rd_vld_reg    <= rd_vld_next;
            match_reg     <= match_next;
            free_reg      <= free_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        cmd_reg          <= cmd_next;
        id_reg           <= id_next;
        delay_reg        <= delay_next;
        rd_idx_reg       <= rd_idx_next;
        free_idx_reg     <= free_idx_next;
        res_task_reg     <= res_task_next;
        res_drop_reg     <= res_drop_next;
        res_full_reg     <= res_full_next;
        next_task_reg    <= next_task_next;
        task_valid_reg   <= task_valid_next;
        push_dropped_reg <= push_dropped_next;
        timer_full_reg   <= timer_full_next;
    end

    // Ready queue memory, used as a ring buffer.
    always_ff @(posedge clk)
    begin
        if (fifo_we)
        begin
            fifo_mem[fifo_waddr] <= fifo_wdata;
        end
        if (fifo_re)
        begin
            fifo_q <= fifo_mem[head_reg];
        end
    end

    // Timer table memory; slot occupancy lives in the valid bits.
    always_ff @(posedge clk)
    begin
        if (tm_we)
        begin
            timer_mem[tm_waddr] <= tm_wdata;
        end
        if (tm_re)
        begin
            timer_q <= timer_mem[issue_idx_reg];
        end
    end

    assign out_valid    = out_valid_reg;
    assign next_task    = next_task_reg;
    assign task_valid   = task_valid_reg;
    assign push_dropped = push_dropped_reg;
    assign timer_full   = timer_full_reg;

    // The queue occupancy never passes its capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QUEUE_CAP)
        else $error("ready queue count above capacity");

    // A write into the queue only happens when there is room.
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_we |-> (count_reg < QUEUE_CAP))
        else $error("ready queue written while full");

    // A table-full result never comes with a popped task or a drop.
    a_full_alone: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && timer_full) |-> (!push_dropped && next_task == tftt_pkg::NO_TASK))
        else $error("timer_full mixed with other result flags");

    // During the walk a slot is written back only after it was read.
    a_walk_order: assert property (@(posedge clk) disable iff (!rst_n)
        (tm_we && state_reg == ST_WALK) |-> rd_vld_reg)
        else $error("timer slot written without a pending read");

endmodule

`default_nettype wire

[bench/task_fifo_with_timer_table_top_tb.sv]
`timescale 1ns / 1ps

module task_fifo_with_timer_table_top_tb;

    localparam int QUEUE_SLOTS = 8;
    localparam int TIMER_SLOTS = 8;
    localparam int STALL_LIMIT = 5000;
    localparam int RANDOM_ITEMS = 1700;

    // One result as the block reports it.
    typedef struct {
        bit [7:0] next_task;
        bit       task_valid;
        bit       push_dropped;
        bit       timer_full;
    } dispatch_result_t;

    // Mirrors the dispatcher state and holds the results still owed by the block.
    class dispatch_scoreboard;
        bit [7:0]         ready_ids[$];
        bit [7:0]         slot_task[TIMER_SLOTS];
        bit [15:0]        slot_left[TIMER_SLOTS];
        dispatch_result_t expected_results[$];
        int               errors;

        function new();
            errors = 0;
            foreach (slot_task[i])
            begin
                slot_task[i] = tftt_pkg::NO_TASK;
                slot_left[i] = '0;
            end
        endfunction

        // Appends a task to the ready queue; returns 1 when there is no room.
        function bit enqueue_ready(bit [7:0] id);
            if (id == tftt_pkg::NO_TASK)
                return 1'b0;
            if (ready_ids.size() >= QUEUE_SLOTS)
                return 1'b1;
            ready_ids.push_back(id);
            return 1'b0;
        endfunction

        // Applies one accepted request to the mirror and records its result.
        function void note_request(tftt_pkg::cmd_t cmd, bit [7:0] id, bit [15:0] dly);
            dispatch_result_t res;
            bit               placed;
            res = '{default: 0};
            placed = 1'b0;
            case (cmd)
                tftt_pkg::CMD_PUSH:
                    res.push_dropped = enqueue_ready(id);
                tftt_pkg::CMD_POP:
                    if (ready_ids.size() != 0)
                        res.next_task = ready_ids.pop_front();
                tftt_pkg::CMD_SET:
                    if (id != tftt_pkg::NO_TASK)
                    begin
                        // A slot already holding the task is re-timed first.
                        foreach (slot_task[i])
                            if (!placed && slot_task[i] == id)
                            begin
                                slot_left[i] = dly;
                                placed = 1'b1;
                            end
                        foreach (slot_task[i])
                            if (!placed && slot_task[i] == tftt_pkg::NO_TASK)
                            begin
                                slot_task[i] = id;
                                slot_left[i] = dly;
                                placed = 1'b1;
                            end
                        res.timer_full = !placed;
                    end
                tftt_pkg::CMD_TICK:
                    // Expiring slots release in index order and are freed even
                    // when their push is dropped.
                    foreach (slot_task[i])
                        if (slot_task[i] != tftt_pkg::NO_TASK)
                        begin
                            if (slot_left[i] != tftt_pkg::EXPIRE_COUNT)
                                slot_left[i] = slot_left[i] - 16'd1;
                            else
                            begin
                                if (enqueue_ready(slot_task[i]))
                                    res.push_dropped = 1'b1;
                                slot_task[i] = tftt_pkg::NO_TASK;
                            end
                        end
                default:
                    ;
            endcase
            res.task_valid = (res.next_task != tftt_pkg::NO_TASK);
            expected_results.push_back(res);
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got)
            begin
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, want, got);
                errors++;
            end
        endfunction

        // Compares one result from the block with the oldest expectation.
        function void check_result(dispatch_result_t got);
            dispatch_result_t want;
            if (expected_results.size() == 0)
            begin
                $display("%0t: result with nothing expected, actual next_task %0d %s",
                         $time, got.next_task, "valid/dropped/full:");
                $display("    %0b %0b %0b", got.task_valid, got.push_dropped,
                         got.timer_full);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            compare_field("next_task", want.next_task, got.next_task);
            compare_field("task_valid", want.task_valid, got.task_valid);
            compare_field("push_dropped", want.push_dropped, got.push_dropped);
            compare_field("timer_full", want.timer_full, got.timer_full);
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  command;
    logic [7:0]  task_id;
    logic [15:0] delay;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  next_task;
    logic        task_valid;
    logic        push_dropped;
    logic        timer_full;

    dispatch_scoreboard sb = new();
    bit                 steady = 1'b0;
    int                 quiet_cycles = 0;

    task_fifo_with_timer_table_top #(
        .QUEUE_SLOTS(QUEUE_SLOTS),
        .TIMER_SLOTS(TIMER_SLOTS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .command(command),
        .task_id(task_id),
        .delay(delay),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .next_task(next_task),
        .task_valid(task_valid),
        .push_dropped(push_dropped),
        .timer_full(timer_full)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // The result side stalls at random except during the steady stretch.
    always @(negedge clk)
    begin
        if (rst_n)
            out_ready = steady || ($urandom_range(99) >= 23);
    end

    // Every accepted result is checked against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result('{next_task, task_valid, push_dropped, timer_full});
    end

    // The run is abandoned when neither channel moves for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // Presents one request, possibly after a random gap, and waits until it is taken.
    task automatic send_request(tftt_pkg::cmd_t cmd, bit [7:0] id, bit [15:0] dly);
        @(negedge clk);
        if (!steady && $urandom_range(99) < 23)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        in_valid = 1'b1;
        command = cmd;
        task_id = id;
        delay = dly;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_request(cmd, id, dly);
    endtask

    // Holds the request side idle until every owed result has come back.
    task automatic wait_for_drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (TIMER_SLOTS + 6) @(posedge clk);
    endtask

    // Corner cases: empty and full queue, idle task, full table, mass expiry.
    task automatic run_directed();
        bit [7:0] push_ids[8];
        push_ids = '{8'd1, 8'd255, 8'd85, 8'd170, 8'd1, 8'd64, 8'd2, 8'd127};
        send_request(tftt_pkg::CMD_POP, 8'd0, 16'hFFFF);
        send_request(tftt_pkg::CMD_PUSH, tftt_pkg::NO_TASK, 16'd0);
        // Fill the queue, with one task in it twice, then overflow it.
        foreach (push_ids[i])
            send_request(tftt_pkg::CMD_PUSH, push_ids[i], 16'd0);
        send_request(tftt_pkg::CMD_PUSH, 8'd200, 16'd0);
        send_request(tftt_pkg::CMD_POP, 8'd255, 16'd0);
        send_request(tftt_pkg::CMD_POP, 8'd0, 16'd0);
        send_request(tftt_pkg::CMD_SET, tftt_pkg::NO_TASK, 16'd1);
        // Fill the timer table with the delay extremes.
        send_request(tftt_pkg::CMD_SET, 8'd9, 16'd1);
        send_request(tftt_pkg::CMD_SET, 8'd10, 16'd0);
        send_request(tftt_pkg::CMD_SET, 8'd11, 16'hFFFF);
        send_request(tftt_pkg::CMD_SET, 8'd12, 16'd2);
        for (int id = 13; id <= 16; id++)
            send_request(tftt_pkg::CMD_SET, id[7:0], 16'd1);
        send_request(tftt_pkg::CMD_SET, 8'd17, 16'd5);
        send_request(tftt_pkg::CMD_SET, 8'd12, 16'd1);
        // Six slots expire at once into a queue with room for two.
        send_request(tftt_pkg::CMD_TICK, 8'd0, 16'd0);
    endtask

    // Random mix that alternates between filling and draining phases.
    task automatic run_random(int count);
        int             done;
        int             pick;
        int             push_share;
        tftt_pkg::cmd_t cmd;
        bit [7:0]       id;
        bit [15:0]      dly;
        done = 0;
        while (done < count)
        begin
            steady = (done >= 700 && done < 1000);
            if (done > 0 && done % 400 == 0)
                wait_for_drain();
            push_share = ((done / 150) % 2 == 0) ? 40 : 20;
            pick = $urandom_range(99);
            if (pick < push_share)
                cmd = tftt_pkg::CMD_PUSH;
            else if (pick < 60)
                cmd = tftt_pkg::CMD_POP;
            else if (pick < 80)
                cmd = tftt_pkg::CMD_SET;
            else
                cmd = tftt_pkg::CMD_TICK;
            // Set timer ids mostly come from a small pool so that re-timing happens.
            pick = $urandom_range(99);
            if (pick < 4)
                id = tftt_pkg::NO_TASK;
            else if (cmd == tftt_pkg::CMD_SET && pick < 85)
                id = $urandom_range(1, 12);
            else
                id = $urandom_range(1, 255);
            pick = $urandom_range(99);
            if (pick < 3)
                dly = 16'd0;
            else if (pick < 5)
                dly = 16'hFFFF;
            else if (pick < 10)
                dly = $urandom_range(0, 65535);
            else
                dly = $urandom_range(1, 6);
            send_request(cmd, id, dly);
            if (!((cmd == tftt_pkg::CMD_PUSH || cmd == tftt_pkg::CMD_SET)
                  && id == tftt_pkg::NO_TASK))
                done++;
        end
        steady = 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        command = tftt_pkg::CMD_PUSH;
        task_id = '0;
        delay = '0;
        out_ready = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        run_directed();
        wait_for_drain();
        run_random(RANDOM_ITEMS);
        wait_for_drain();

        if (sb.errors == 0 && sb.pending() == 0)
            $display("Test completed successfully");
        else
        begin
            if (sb.pending() != 0)
                $display("%0t: %0d expected results never arrived", $time, sb.pending());
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
